@@ rtl/core/wsti_pkg.sv @@
// Package for the wrapping sample table interpolator.
// Field widths, fixed-point constants, mode and register codes, FSM and
// controller/datapath interface types. No dependencies.
package wsti_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_BITS  = 8;
  localparam int DEPTH_DEF   = 4096;

  localparam int MODE_W = 2;
  localparam int LEN_W  = 13;
  localparam int WIDX_W = 12;
  localparam int POS_W  = 28;
  localparam int IPOS_W = POS_W - FRAC_BITS;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam int COEF_W = SAMPLE_BITS + 4;
  localparam int ACC_W  = 32;
  localparam int PROD_W = ACC_W + FRAC_BITS + 1;
  localparam int RES_W  = 24;

  // floor(n / 3) as (n * DIV_MAGIC) >> DIV_SHIFT, exact for n below 2^32
  localparam int DIV_W     = 24;
  localparam int DIV_SHIFT = 33;
  localparam logic [31:0] DIV_MAGIC = 32'hAAAA_AAAB;
  localparam int DIV_BIAS_EXP = RES_W - 4;
  localparam int QPROD_W = DIV_W + 32;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BSPLINE = 2'd3;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LAST,
    ST_COEF,
    ST_MUL,
    ST_LIN,
    ST_ACC,
    ST_POLY,
    ST_DIV_MUL,
    ST_DIV_RES,
    ST_DONE
  } wsti_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_WRITE,
    DP_LATCH,
    DP_FETCH,
    DP_LAST,
    DP_COEF,
    DP_MUL,
    DP_LIN,
    DP_ACC,
    DP_POLY,
    DP_DIV_MUL,
    DP_DIV_RES,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] sel;
  } wsti_cmd_t;

  typedef struct packed {
    logic pos_err;
    logic out_free;
  } wsti_status_t;

endpackage

@@ rtl/core/wsti_ctrl.sv @@
// Controller FSM of the wrapping sample table interpolator.
// Sequences table fetches, Horner steps and result hand-off; uses wsti_pkg.
module wsti_ctrl
  import wsti_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  wsti_status_t        status_i,
  output wsti_cmd_t           cmd_o
);

  wsti_state_e state_q, state_d;
  logic [1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_action_i) begin
          state_d = status_i.pos_err ? ST_DONE : ST_FETCH;
          cnt_d   = 2'd0;
        end
      end
      ST_FETCH: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_COEF;
      ST_COEF: begin
        cnt_d   = 2'd0;
        state_d = (mode_i == MODE_NEAREST) ? ST_DONE : ST_MUL;
      end
      ST_MUL: state_d = (mode_i == MODE_LINEAR) ? ST_LIN : ST_ACC;
      ST_LIN: state_d = ST_DONE;
      ST_ACC: begin
        if (cnt_q == 2'd2) begin
          state_d = ST_POLY;
        end else begin
          state_d = ST_MUL;
          cnt_d   = cnt_q + 2'd1;
        end
      end
      ST_POLY:    state_d = (mode_i == MODE_BSPLINE) ? ST_DIV_MUL : ST_DONE;
      ST_DIV_MUL: state_d = ST_DIV_RES;
      ST_DIV_RES: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.sel  = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = in_action_i ? DP_LATCH : DP_WRITE;
        end
      end
      ST_FETCH:   cmd_o.op = DP_FETCH;
      ST_LAST:    cmd_o.op = DP_LAST;
      ST_COEF:    cmd_o.op = DP_COEF;
      ST_MUL:     cmd_o.op = DP_MUL;
      ST_LIN:     cmd_o.op = DP_LIN;
      ST_ACC:     cmd_o.op = DP_ACC;
      ST_POLY:    cmd_o.op = DP_POLY;
      ST_DIV_MUL: cmd_o.op = DP_DIV_MUL;
      ST_DIV_RES: cmd_o.op = DP_DIV_RES;
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_OUT;
        end
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

endmodule

@@ rtl/core/wsti_dp.sv @@
// Datapath of the wrapping sample table interpolator: sample RAM, neighbor
// index wrap, coefficient build, shared Horner multiplier, divide by three,
// saturation and output register. Uses wsti_pkg.
module wsti_dp
  import wsti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
)(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wsti_cmd_t               cmd_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [LEN_W-1:0]        table_length_i,
  input  logic [IN_TDATA_W-1:0]   in_data_i,
  input  logic                    out_ready_i,
  output wsti_status_t            status_o,
  output logic                    out_valid_o,
  output logic [SAMPLE_BITS-1:0]  out_sample_o,
  output logic                    out_err_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic signed [PROD_W-1:0] LIN_RND = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  HER_RND = ACC_W'(1) <<< GUARD_BITS;
  localparam logic signed [ACC_W-1:0]  BSP_RND = ACC_W'(3) <<< GUARD_BITS;
  localparam logic [DIV_W-1:0]         DIV_OFS = DIV_W'(3) << DIV_BIAS_EXP;
  localparam logic signed [RES_W-1:0]  DIV_BIAS = RES_W'(1) <<< DIV_BIAS_EXP;
  localparam logic signed [RES_W-1:0]  S_MAX = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RES_W-1:0]  S_MIN = -S_MAX - RES_W'(1);

  // input beat fields
  logic [WIDX_W-1:0]             w_idx;
  logic signed [SAMPLE_BITS-1:0] w_val;
  logic [POS_W-1:0]              pos;

  assign w_idx = in_data_i[WIDX_W-1:0];
  assign w_val = in_data_i[WIDX_W +: SAMPLE_BITS];
  assign pos   = in_data_i[WIDX_W + SAMPLE_BITS +: POS_W];

  // effective length and neighbor indices
  logic [LEN_W-1:0] len_eff, ipos, i0, i2, i3;

  always_comb begin
    len_eff = table_length_i;
    if (table_length_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(table_length_i) > 32'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end
    ipos = LEN_W'(pos[POS_W-1:FRAC_BITS]);
    i0   = (ipos == '0) ? len_eff - LEN_W'(1) : ipos - LEN_W'(1);
    i2   = (ipos + LEN_W'(1) == len_eff) ? '0 : ipos + LEN_W'(1);
    i3   = (i2 + LEN_W'(1) == len_eff) ? '0 : i2 + LEN_W'(1);
  end

  assign status_o.pos_err  = (ipos >= len_eff);
  assign status_o.out_free = !out_valid_o || out_ready_i;

  // sample RAM, single port, registered read
  logic signed [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic [AW-1:0]                 idx_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_WRITE) begin
      if (32'(w_idx) < 32'(TABLE_DEPTH)) begin
        mem[AW'(w_idx)] <= w_val;
      end
    end else if (cmd_i.op == DP_FETCH) begin
      rdata_q <= mem[idx_q[cmd_i.sel]];
    end
  end

  // item registers
  logic [FRAC_BITS-1:0]          frac_q;
  logic                          err_q;
  logic signed [SAMPLE_BITS-1:0] x_q [4];
  logic signed [COEF_W-1:0]      coef_q [3];
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic [DIV_W-1:0]              dnum_q;
  logic [QPROD_W-1:0]            qprod_q;
  logic signed [RES_W-1:0]       res_q;

  // coefficients
  logic signed [COEF_W-1:0] e0, e1, e2, e3;
  logic signed [COEF_W-1:0] h3, h2, h1, h0, b3, b2, b1, b0;
  logic signed [ACC_W-1:0]  poly_rnd;
  logic signed [RES_W-1:0]  poly_res, lin_res, sat_res;

  always_comb begin
    e0 = COEF_W'(x_q[0]);
    e1 = COEF_W'(x_q[1]);
    e2 = COEF_W'(x_q[2]);
    e3 = COEF_W'(x_q[3]);
    h3 = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
    h2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    h1 = e2 - e0;
    h0 = e1 <<< 1;
    b3 = (e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2);
    b2 = ((e0 + e2) <<< 1) + (e0 + e2) - ((e1 <<< 2) + (e1 <<< 1));
    b1 = ((e2 - e0) <<< 1) + (e2 - e0);
    b0 = e0 + (e1 <<< 2) + e2;
    poly_rnd = (mode_i == MODE_BSPLINE) ? BSP_RND : HER_RND;
    poly_res = RES_W'((acc_q + poly_rnd) >>> (GUARD_BITS + 1));
    lin_res  = RES_W'(x_q[1]) + RES_W'((prod_q + LIN_RND) >>> FRAC_BITS);
    if (res_q > S_MAX) begin
      sat_res = S_MAX;
    end else if (res_q < S_MIN) begin
      sat_res = S_MIN;
    end else begin
      sat_res = res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LATCH: begin
        frac_q   <= pos[FRAC_BITS-1:0];
        err_q    <= status_o.pos_err;
        idx_q[0] <= AW'(i0);
        idx_q[1] <= AW'(ipos);
        idx_q[2] <= AW'(i2);
        idx_q[3] <= AW'(i3);
      end
      DP_FETCH: begin
        if (cmd_i.sel != 2'd0) begin
          x_q[cmd_i.sel - 2'd1] <= rdata_q;
        end
      end
      DP_LAST: x_q[3] <= rdata_q;
      DP_COEF: begin
        res_q <= RES_W'(x_q[1]);
        if (mode_i == MODE_LINEAR) begin
          acc_q <= ACC_W'(e2 - e1);
        end else if (mode_i == MODE_BSPLINE) begin
          acc_q     <= ACC_W'(b3) <<< GUARD_BITS;
          coef_q[0] <= b2;
          coef_q[1] <= b1;
          coef_q[2] <= b0;
        end else begin
          acc_q     <= ACC_W'(h3) <<< GUARD_BITS;
          coef_q[0] <= h2;
          coef_q[1] <= h1;
          coef_q[2] <= h0;
        end
      end
      DP_MUL:  prod_q <= PROD_W'(acc_q) * PROD_W'($signed({1'b0, frac_q}));
      DP_LIN:  res_q  <= lin_res;
      DP_ACC: begin
        acc_q <= ACC_W'(prod_q >>> FRAC_BITS)
               + (ACC_W'(coef_q[cmd_i.sel]) <<< GUARD_BITS);
      end
      DP_POLY: begin
        res_q  <= poly_res;
        dnum_q <= DIV_W'(poly_res) + DIV_OFS;
      end
      DP_DIV_MUL: qprod_q <= QPROD_W'(dnum_q) * QPROD_W'(DIV_MAGIC);
      DP_DIV_RES: res_q   <= RES_W'(qprod_q >> DIV_SHIFT) - DIV_BIAS;
      default: ;
    endcase
  end

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic                   out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT) begin
      out_sample_q <= err_q ? '0 : sat_res[SAMPLE_BITS-1:0];
      out_err_q    <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_err_o    = out_err_q;

endmodule

@@ rtl/core/wrapping_sample_table_interpolator_unit.sv @@
// Top level of the wrapping sample table interpolator: APB registers and
// stream ports around wsti_ctrl and wsti_dp. Uses wsti_pkg.
//
// A write beat (tuser 0) stores one sample. A read beat (tuser 1) skips to
// hand-off on a range error; else it does four serial fetches from the
// single-port sample RAM, then a multiply in linear mode or three steps of
// the shared Horner multiplier (a multiply and an accumulate each) in
// Hermite and B-spline, B-spline adding a divide by three. The next beat is
// accepted while a finished result waits on the master side. The sample
// RAM is not cleared; read only slots already written.
module wrapping_sample_table_interpolator_unit
  import wsti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
)(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: write_index[11:0], write_value[27:12], read_position[55:28]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: action[0]
  input  logic [0:0]             s_axis_tuser_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: sample_out[15:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: range_error[0]
  output logic [0:0]             m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  len_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HERMITE;
      len_q  <= LEN_W'(4096);
    end else if (cfg_we) begin
      if (paddr[2] == REG_MODE) begin
        mode_q <= pwdata[MODE_W-1:0];
      end else begin
        len_q <= pwdata[LEN_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_LEN) ? APB_DW'(len_q) : APB_DW'(mode_q);

  wsti_cmd_t    cmd;
  wsti_status_t status;

  wsti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i[0]),
    .in_ready_o  (s_axis_tready_o),
    .mode_i      (mode_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wsti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_q),
    .table_length_i (len_q),
    .in_data_i      (s_axis_tdata_i),
    .out_ready_i    (m_axis_tready_i),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid_o),
    .out_sample_o   (m_axis_tdata_o),
    .out_err_o      (m_axis_tuser_o[0])
  );

endmodule

@@ test/tb_wrapping_sample_table_interpolator_unit.sv @@
// Self-checking testbench for wrapping_sample_table_interpolator_unit: stream beats,
// APB register writes and an in-bench predictor of all four interpolation modes.
// Depends on wsti_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_wrapping_sample_table_interpolator_unit;
  import wsti_pkg::*;

  localparam int TABLE_SLOTS  = DEPTH_DEF;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_BEATS = 1350;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam longint ONE_F  = longint'(1) << FRAC_BITS;
  localparam longint HALF_F = longint'(1) << (FRAC_BITS - 1);
  localparam longint ONE_G  = longint'(1) << GUARD_BITS;
  localparam longint S_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN  = -S_MAX - 1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [APB_AW-1:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_LEN  = {REG_LEN, 2'b00};

  typedef struct {
    logic signed [15:0] sample;
    logic               range_err;
  } result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata    = '0;
  logic [0:0]             s_tuser    = '0;
  logic                   s_tvalid   = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tvalid;
  logic                   m_tready   = 1'b0;
  logic                   apb_sel    = 1'b0;
  logic                   apb_enable = 1'b0;
  logic                   apb_write  = 1'b0;
  logic [APB_AW-1:0]      apb_addr   = '0;
  logic [APB_DW-1:0]      apb_wdata  = '0;
  logic [APB_DW-1:0]      apb_rdata;
  logic                   apb_ready;

  // predictor state
  logic signed [15:0] sample_mem [TABLE_SLOTS];
  bit                 slot_loaded [TABLE_SLOTS];
  logic [1:0]         cur_mode = MODE_HERMITE;
  logic [12:0]        cur_len  = 13'd4096;

  result_t     expected_q [$];
  result_t     want;
  int          errors      = 0;
  int          beats_sent  = 0;
  int          burst_left  = 0;
  int unsigned cycle_count = 0;

  wrapping_sample_table_interpolator_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .psel            (apb_sel),
    .penable         (apb_enable),
    .pwrite          (apb_write),
    .paddr           (apb_addr),
    .pwdata          (apb_wdata),
    .prdata          (apb_rdata),
    .pready          (apb_ready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_wrapping_sample_table_interpolator_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int eff_len();
    if (cur_len == 0) return 1;
    if (cur_len > TABLE_SLOTS) return TABLE_SLOTS;
    return cur_len;
  endfunction

  function automatic void neighbors(input int i, input int len,
                                    output int n0, n1, n2, n3);
    n0 = (i == 0) ? len - 1 : i - 1;
    n1 = i;
    n2 = (i + 1 == len) ? 0 : i + 1;
    n3 = (n2 + 1 == len) ? 0 : n2 + 1;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint poly_eval(longint c3, longint c2, longint c1, longint c0,
                                       longint f);
    longint a;
    a = c3 * ONE_G;
    a = ((a * f) >>> FRAC_BITS) + c2 * ONE_G;
    a = ((a * f) >>> FRAC_BITS) + c1 * ONE_G;
    a = ((a * f) >>> FRAC_BITS) + c0 * ONE_G;
    return a;
  endfunction

  function automatic result_t interpolate(logic [27:0] pos);
    int      len, i, n0, n1, n2, n3;
    longint  f, x0, x1, x2, x3, r;
    result_t res;
    len = eff_len();
    i   = pos[27:16];
    f   = pos[15:0];
    if (i >= len) begin
      res.sample    = '0;
      res.range_err = 1'b1;
      return res;
    end
    neighbors(i, len, n0, n1, n2, n3);
    x0 = sample_mem[n0];
    x1 = sample_mem[n1];
    x2 = sample_mem[n2];
    x3 = sample_mem[n3];
    case (cur_mode)
      MODE_NEAREST: r = x1;
      MODE_LINEAR:  r = x1 + (((x2 - x1) * f + HALF_F) >>> FRAC_BITS);
      MODE_HERMITE: begin
        r = poly_eval((x3 - x0) + 3 * (x1 - x2), 2 * x0 - 5 * x1 + 4 * x2 - x3,
                      x2 - x0, 2 * x1, f);
        r = (r + ONE_G) >>> (GUARD_BITS + 1);
      end
      default: begin
        r = poly_eval(-x0 + 3 * x1 - 3 * x2 + x3, 3 * x0 - 6 * x1 + 3 * x2,
                      3 * x2 - 3 * x0, x0 + 4 * x1 + x2, f);
        r = floor_div(r + 3 * ONE_G, 6 * ONE_G);
      end
    endcase
    if (r > S_MAX) r = S_MAX;
    if (r < S_MIN) r = S_MIN;
    res.sample    = r[15:0];
    res.range_err = 1'b0;
    return res;
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_beat(input logic act, input logic [11:0] widx,
                           input logic [15:0] wval, input logic [27:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {pos, wval, widx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (act == ACT_WRITE) begin
      sample_mem[widx]  = wval;
      slot_loaded[widx] = 1'b1;
    end else begin
      expected_q.push_back(interpolate(pos));
    end
  endtask

  task automatic write_slot(input logic [11:0] idx, input logic [15:0] val);
    send_beat(ACT_WRITE, idx, val, 28'($urandom));
  endtask

  task automatic load_slot(input int idx);
    if (!slot_loaded[idx]) write_slot(12'(idx), 16'($urandom));
  endtask

  // fills any never-written neighbor first so no read touches an unwritten slot
  task automatic read_pos(input logic [27:0] pos);
    int len, i, n0, n1, n2, n3;
    len = eff_len();
    i   = pos[27:16];
    if (i < len) begin
      neighbors(i, len, n0, n1, n2, n3);
      load_slot(n0);
      load_slot(n1);
      load_slot(n2);
      load_slot(n3);
    end
    send_beat(ACT_READ, 12'($urandom), 16'($urandom), pos);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic configure(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_sel   <= 1'b1;
    apb_write <= 1'b1;
    apb_addr  <= addr;
    apb_wdata <= data;
    @(negedge clk);
    apb_enable <= 1'b1;
    @(posedge clk);
    while (!apb_ready) @(posedge clk);
    if (addr == ADDR_MODE) cur_mode = data[1:0];
    else cur_len = data[12:0];
    @(negedge clk);
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ------------------------------------------------------------ receiver side

  int stall_style = 0;
  int style_left  = 0;
  int stall_left  = 0;

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(50, 300);
    end
    style_left--;
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(2, 11);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: sample_out %0d range_error %0b",
                 $time, $signed(m_tdata), m_tuser[0]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if ($signed(m_tdata) !== want.sample) begin
          $display("%0t sample_out mismatch: expected %0d, actual %0d",
                   $time, want.sample, $signed(m_tdata));
          errors++;
        end
        if (m_tuser[0] !== want.range_err) begin
          $display("%0t range_error mismatch: expected %0b, actual %0b",
                   $time, want.range_err, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // reset config: Hermite, full table; wrap at both table ends
  task automatic test_table_edges();
    write_slot(12'd0, 16'h7FFF);
    write_slot(12'hFFF, 16'h8000);
    read_pos({12'd0, 16'h0000});
    read_pos({12'hFFF, 16'hFFFF});
    read_pos({12'd2048, 16'h8000});
  endtask

  // alternating full-scale samples, read back in all four interpolation modes
  task automatic test_interp_modes();
    configure(ADDR_LEN, 32'd4);
    write_slot(12'd0, 16'h7FFF);
    write_slot(12'd1, 16'h8000);
    write_slot(12'd2, 16'h7FFF);
    write_slot(12'd3, 16'h8000);
    for (int m = MODE_NEAREST; m <= MODE_BSPLINE; m++) begin
      configure(ADDR_MODE, m);
      read_pos({12'd1, 16'h8000});
      read_pos({12'd3, 16'hFFFF});
    end
  endtask

  task automatic test_length_limits();
    configure(ADDR_LEN, 32'd0);
    read_pos({12'd0, 16'hFFFF});
    read_pos({12'd1, 16'h0000});
    read_pos(28'hFFFFFFF);
    configure(ADDR_LEN, 32'd5);
    write_slot(12'd100, 16'h1234);
    read_pos({12'd5, 16'h0000});
    read_pos({12'd4, 16'h4000});
    configure(ADDR_LEN, 32'd8191);
    read_pos({12'd100, 16'h0001});
    read_pos({12'hFFF, 16'h8000});
    configure(ADDR_LEN, 32'd4097);
    read_pos({12'hFFE, 16'hC000});
  endtask

  task automatic test_random_traffic();
    int target, phase, n, k, len, lv;
    target = beats_sent + RANDOM_BEATS;
    phase  = 0;
    while (beats_sent < target) begin
      configure(ADDR_MODE, $urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       lv = TABLE_SLOTS;
        1:       lv = $urandom_range(0, 8191);
        2:       lv = $urandom_range(0, 3);
        default: lv = $urandom_range(4, 64);
      endcase
      configure(ADDR_LEN, lv);
      len = eff_len();
      n   = $urandom_range(40, 120);
      for (int j = 0; j < n; j++) begin
        // let the pipe run dry mid-phase now and then
        if (j == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) wait_for_results();
        k = $urandom_range(0, 99);
        if (k < 20) write_slot(12'($urandom_range(0, len - 1)), rand_sample());
        else if (k < 30) write_slot(12'($urandom), rand_sample());
        else if (k < 94) read_pos({12'($urandom_range(0, len - 1)), rand_frac()});
        else read_pos(28'($urandom));
      end
      phase++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_table_edges();
    test_interp_modes();
    test_length_limits();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_wrapping_sample_table_interpolator_unit passed");
    end else begin
      $display("tb_wrapping_sample_table_interpolator_unit failed");
    end
    $finish;
  end

endmodule

@@ wrapping_sample_table_interpolator_unit.f @@
rtl/core/wsti_pkg.sv
rtl/core/wsti_ctrl.sv
rtl/core/wsti_dp.sv
rtl/core/wrapping_sample_table_interpolator_unit.sv
test/tb_wrapping_sample_table_interpolator_unit.sv
